>>> hdl/pfsa_pkg.sv
// Shared constants and codes for the page-frame stack allocator.
// No dependencies.
package pfsa_pkg;

  localparam int unsigned MAX_FRAMES = 4096;
  localparam int unsigned PAGE_BITS  = 12;
  localparam int unsigned FRAME_W    = $clog2(MAX_FRAMES);
  localparam int unsigned CNT_W      = FRAME_W + 1;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned REF_W      = 8;

  localparam logic [2:0] CMD_INIT      = 3'd0;
  localparam logic [2:0] CMD_ALLOC     = 3'd1;
  localparam logic [2:0] CMD_FREE      = 3'd2;
  localparam logic [2:0] CMD_INC_REF   = 3'd3;
  localparam logic [2:0] CMD_MARK_USED = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OOM      = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] REG_RAM_BASE   = 2'd0;
  localparam logic [1:0] REG_RAM_FRAMES = 2'd1;
  localparam logic [1:0] REG_KERNEL_END = 2'd2;

endpackage

>>> hdl/page_frame_stack_allocator.sv
// Page-frame allocator: free-frame stack and reference counts in two
// synchronous RAMs, driven by a sequencer. Depends on pfsa_pkg.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid_i/in_ready_o | command, phys_address, region_bytes
//  out     | output    | out_valid_o/out_ready_i | status, frame_address, free/used count
//  cfg     | input     | APB psel/penable    | ram_base, ram_frames, kernel_end_address
//
// Alloc steps through S_ALC and S_ALC2, free and inc_ref through S_IDX, S_CHK and S_RC;
// each RAM read is registered. Init walks all MAX_FRAMES count entries, one per cycle.
// Mark_used scans the stack entry by entry (S_SRD, S_SCMP) for each frame of the region.
// After reset a clearing pass over all MAX_FRAMES entries zeroes the counts; no transfer
// is taken meanwhile. A stalled output holds the finished item in its last state.
module page_frame_stack_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                command_i,
  input  logic [pfsa_pkg::ADDR_W-1:0] phys_address_i,
  input  logic [31:0]               region_bytes_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [pfsa_pkg::ADDR_W-1:0] frame_address_o,
  output logic [pfsa_pkg::CNT_W-1:0] free_count_o,
  output logic [pfsa_pkg::CNT_W-1:0] used_count_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [4:0]                paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready
);
  import pfsa_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_INI0 = 4'd2;
  localparam logic [3:0] S_INIT = 4'd3;
  localparam logic [3:0] S_ALC  = 4'd4;
  localparam logic [3:0] S_ALC2 = 4'd5;
  localparam logic [3:0] S_IDX  = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_RC   = 4'd8;
  localparam logic [3:0] S_END  = 4'd9;
  localparam logic [3:0] S_TCHK = 4'd10;
  localparam logic [3:0] S_SRD  = 4'd11;
  localparam logic [3:0] S_SCMP = 4'd12;
  localparam logic [3:0] S_MV   = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  localparam logic [ADDR_W-1:0] PAGE_MASK   = ADDR_W'((64'd1 << PAGE_BITS) - 64'd1);
  localparam logic [ADDR_W-1:0] FRAME_BYTES = ADDR_W'(64'd1 << PAGE_BITS);
  localparam logic [CNT_W-1:0]  MAX_CNT     = CNT_W'(MAX_FRAMES);
  localparam logic [CNT_W-1:0]  LAST_IDX    = CNT_W'(MAX_FRAMES - 1);
  localparam logic [REF_W-1:0]  REF_MAX     = '1;

  // configuration
  logic [ADDR_W-1:0] ram_base_q, kernel_end_q;
  logic [CNT_W-1:0]  ram_frames_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_base_q   <= 64'd1073741824;
      ram_frames_q <= MAX_CNT;
      kernel_end_q <= 64'd1073741824;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_RAM_BASE:   ram_base_q   <= pwdata;
        REG_RAM_FRAMES: ram_frames_q <= pwdata[CNT_W-1:0];
        REG_KERNEL_END: kernel_end_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_RAM_BASE:   prdata = ram_base_q;
      REG_RAM_FRAMES: prdata = {{(64-CNT_W){1'b0}}, ram_frames_q};
      REG_KERNEL_END: prdata = kernel_end_q;
      default:        prdata = '0;
    endcase
  end

  // memories
  logic [FRAME_W-1:0] stack_mem [MAX_FRAMES];
  logic [REF_W-1:0]   ref_mem   [MAX_FRAMES];
  logic               st_we, st_re, rc_we, rc_re;
  logic [FRAME_W-1:0] st_waddr, st_raddr, st_wdata, st_rdata;
  logic [FRAME_W-1:0] rc_waddr, rc_raddr;
  logic [REF_W-1:0]   rc_wdata, rc_rdata;

  always_ff @(posedge clk_i) begin
    if (st_we) stack_mem[st_waddr] <= st_wdata;
    if (st_re) st_rdata <= stack_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rc_we) ref_mem[rc_waddr] <= rc_wdata;
    if (rc_re) rc_rdata <= ref_mem[rc_raddr];
  end

  // control and working registers
  logic [3:0]         state_q, state_d;
  logic [CNT_W-1:0]   sp_q, sp_d, used_q, used_d, idx_q, idx_d;
  logic [CNT_W-1:0]   t_q, t_d, endk_q, endk_d, i_q, i_d;
  logic [2:0]         cmd_q;
  logic [ADDR_W-1:0]  pa_q, ea_q, ea_d, a_q, a_d, rend_q, rend_d, addr_q, addr_d;
  logic [31:0]        rb_q;
  logic [FRAME_W-1:0] k_q, k_d;
  logic               bad_q, bad_d;
  logic [1:0]         res_q, res_d;
  logic               out_valid_q;
  logic [1:0]         status_q;
  logic [ADDR_W-1:0]  frame_addr_q;
  logic [CNT_W-1:0]   free_out_q, used_out_q;

  logic [CNT_W-1:0]   total;
  logic [ADDR_W-1:0]  idx_src, diff;
  logic               src_bad;
  logic [CNT_W-1:0]   used_inc, used_dec;
  logic               accept, out_load;

  assign total    = (ram_frames_q > MAX_CNT) ? MAX_CNT : ram_frames_q;
  assign used_inc = (used_q < MAX_CNT) ? used_q + 1'b1 : used_q;
  assign used_dec = (used_q != '0) ? used_q - 1'b1 : used_q;

  // shared address-to-index conversion
  assign idx_src = (state_q == S_END) ? ea_q : pa_q;
  assign diff    = idx_src - ram_base_q;
  assign src_bad = (idx_src < ram_base_q) ||
                   ((diff >> PAGE_BITS) >= {{(ADDR_W-CNT_W){1'b0}}, total});

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d  = state_q;
    sp_d     = sp_q;
    used_d   = used_q;
    idx_d    = idx_q;
    t_d      = t_q;
    endk_d   = endk_q;
    i_d      = i_q;
    ea_d     = ea_q;
    a_d      = a_q;
    rend_d   = rend_q;
    addr_d   = addr_q;
    k_d      = k_q;
    bad_d    = bad_q;
    res_d    = res_q;
    st_we    = 1'b0;
    st_re    = 1'b0;
    st_waddr = sp_q[FRAME_W-1:0];
    st_wdata = k_q;
    st_raddr = i_q[FRAME_W-1:0];
    rc_we    = 1'b0;
    rc_re    = 1'b0;
    rc_waddr = k_q;
    rc_wdata = '0;
    rc_raddr = k_q;

    case (state_q)
      S_CLR: begin
        rc_we    = 1'b1;
        rc_waddr = idx_q[FRAME_W-1:0];
        idx_d    = idx_q + 1'b1;
        if (idx_q == LAST_IDX) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          res_d  = ST_OK;
          addr_d = '0;
          case (command_i)
            CMD_INIT: begin
              rend_d  = (kernel_end_q + PAGE_MASK) & ~PAGE_MASK;
              a_d     = ram_base_q;
              idx_d   = '0;
              sp_d    = '0;
              used_d  = '0;
              state_d = S_INI0;
            end
            CMD_ALLOC:     state_d = S_ALC;
            CMD_FREE,
            CMD_INC_REF,
            CMD_MARK_USED: state_d = S_IDX;
            default:       state_d = S_DONE;
          endcase
        end
      end
      S_INI0: begin
        rend_d  = rend_q + ADDR_W'(5 * total);
        state_d = S_INIT;
      end
      S_INIT: begin
        rc_we    = 1'b1;
        rc_waddr = idx_q[FRAME_W-1:0];
        if (idx_q < total) begin
          if (a_q >= ram_base_q && a_q < rend_q) begin
            rc_wdata = REF_W'(1);
            used_d   = used_inc;
          end else begin
            st_we    = 1'b1;
            st_wdata = idx_q[FRAME_W-1:0];
            sp_d     = sp_q + 1'b1;
          end
        end
        a_d   = a_q + FRAME_BYTES;
        idx_d = idx_q + 1'b1;
        if (idx_q == LAST_IDX) state_d = S_DONE;
      end
      S_ALC: begin
        if (sp_q == '0) begin
          res_d   = ST_OOM;
          state_d = S_DONE;
        end else begin
          st_re    = 1'b1;
          st_raddr = FRAME_W'(sp_q - 1'b1);
          sp_d     = sp_q - 1'b1;
          state_d  = S_ALC2;
        end
      end
      S_ALC2: begin
        rc_we    = 1'b1;
        rc_waddr = st_rdata;
        rc_wdata = REF_W'(1);
        used_d   = used_inc;
        addr_d   = ram_base_q + ({{(ADDR_W-FRAME_W){1'b0}}, st_rdata} << PAGE_BITS);
        state_d  = S_DONE;
      end
      S_IDX: begin
        bad_d   = src_bad;
        k_d     = diff[PAGE_BITS +: FRAME_W];
        ea_d    = pa_q + {32'd0, rb_q} + PAGE_MASK;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (bad_q) begin
          res_d   = ST_BAD_ADDR;
          state_d = S_DONE;
        end else if (cmd_q == CMD_MARK_USED) begin
          state_d = S_END;
        end else begin
          rc_re   = 1'b1;
          state_d = S_RC;
        end
      end
      S_RC: begin
        rc_we   = 1'b1;
        state_d = S_DONE;
        if (cmd_q == CMD_INC_REF) begin
          rc_wdata = (rc_rdata != REF_MAX) ? rc_rdata + 1'b1 : rc_rdata;
        end else begin
          rc_wdata = (rc_rdata != '0) ? rc_rdata - 1'b1 : rc_rdata;
          if (rc_rdata == '0 || rc_rdata == REF_W'(1)) begin
            if (sp_q >= total) begin
              res_d = ST_FULL;
            end else begin
              st_we  = 1'b1;
              sp_d   = sp_q + 1'b1;
              used_d = used_dec;
            end
          end
        end
      end
      S_END: begin
        endk_d  = src_bad ? total : {1'b0, diff[PAGE_BITS +: FRAME_W]};
        t_d     = {1'b0, k_q};
        state_d = S_TCHK;
      end
      S_TCHK: begin
        i_d     = '0;
        state_d = (t_q >= endk_q) ? S_DONE : S_SRD;
      end
      S_SRD: begin
        if (i_q >= sp_q) begin
          t_d     = t_q + 1'b1;
          state_d = S_TCHK;
        end else begin
          st_re   = 1'b1;
          state_d = S_SCMP;
        end
      end
      S_SCMP: begin
        if (st_rdata == t_q[FRAME_W-1:0]) begin
          // pull the top entry down into the matching slot
          st_re    = 1'b1;
          st_raddr = FRAME_W'(sp_q - 1'b1);
          sp_d     = sp_q - 1'b1;
          state_d  = S_MV;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_SRD;
        end
      end
      S_MV: begin
        st_we    = 1'b1;
        st_waddr = i_q[FRAME_W-1:0];
        st_wdata = st_rdata;
        used_d   = used_inc;
        t_d      = t_q + 1'b1;
        state_d  = S_TCHK;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      sp_q        <= '0;
      used_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      used_q  <= used_d;
      idx_q   <= idx_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      pa_q  <= phys_address_i;
      rb_q  <= region_bytes_i;
    end
    t_q    <= t_d;
    endk_q <= endk_d;
    i_q    <= i_d;
    ea_q   <= ea_d;
    a_q    <= a_d;
    rend_q <= rend_d;
    addr_q <= addr_d;
    k_q    <= k_d;
    bad_q  <= bad_d;
    res_q  <= res_d;
    if (out_load) begin
      status_q     <= res_q;
      frame_addr_q <= addr_q;
      free_out_q   <= sp_q;
      used_out_q   <= used_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign frame_address_o = frame_addr_q;
  assign free_count_o    = free_out_q;
  assign used_count_o    = used_out_q;

endmodule
